### rtl/core/stl_pkg.sv
// stl_pkg: shared types and constants for the script token lexer.
// No dependencies.
package stl_pkg;

	localparam int ModeW = 3;

	localparam logic [ModeW-1:0] MODE_IDLE    = 3'd0;
	localparam logic [ModeW-1:0] MODE_SLASH   = 3'd1;
	localparam logic [ModeW-1:0] MODE_COMMENT = 3'd2;
	localparam logic [ModeW-1:0] MODE_WORD    = 3'd3;
	localparam logic [ModeW-1:0] MODE_QUOTE   = 3'd4;

	localparam logic [1:0] KIND_WORD   = 2'd0;
	localparam logic [1:0] KIND_QUOTED = 2'd1;
	localparam logic [1:0] KIND_SINGLE = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQUOT = 8'h22;
	localparam logic [7:0] CH_SQUOT = 8'h27;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_LBRC  = 8'h7b;
	localparam logic [7:0] CH_RBRC  = 8'h7d;

	// Result queue depth; an accepted byte may push two beats.
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic [1:0] kind;
		logic       empty;
	} result_t;

	typedef struct packed {
		logic [1:0]       n;
		result_t          r0;
		result_t          r1;
		logic [ModeW-1:0] mode;
		logic [7:0]       held_char;
		logic             held_valid;
	} step_t;

	function automatic logic is_single(input logic [7:0] b);
		return (b == CH_LBRC) || (b == CH_RBRC) || (b == CH_LPAR) ||
			(b == CH_RPAR) || (b == CH_SQUOT) || (b == CH_COMMA);
	endfunction

	function automatic result_t mk(input logic [7:0] ch, input logic last,
		input logic [1:0] kind, input logic empty);
		result_t r;
		r.ch    = ch;
		r.last  = last;
		r.kind  = kind;
		r.empty = empty;
		return r;
	endfunction

endpackage

### rtl/core/stl_step.sv
// stl_step: next-state and emitted beats for one text byte.
// Depends on stl_pkg.
module stl_step (
	input  logic [7:0]              text_byte,
	input  logic [stl_pkg::ModeW-1:0] mode,
	input  logic [7:0]              held_char,
	input  logic                    held_valid,
	output stl_pkg::step_t          step
);

	logic [stl_pkg::ModeW-1:0] eff_mode;
	logic                      is_nul;
	logic                      is_ws;
	logic                      is_sgl;
	stl_pkg::result_t          end_mark;

	assign is_nul   = (text_byte == stl_pkg::CH_NUL);
	assign is_ws    = (text_byte <= stl_pkg::CH_SPACE);
	assign is_sgl   = stl_pkg::is_single(text_byte);
	assign end_mark = stl_pkg::mk(stl_pkg::CH_NUL, 1'b1, stl_pkg::KIND_END, 1'b0);

	// a lone slash not followed by another slash opens a word
	always_comb begin
		if (mode == stl_pkg::MODE_SLASH && text_byte != stl_pkg::CH_SLASH) begin
			eff_mode = stl_pkg::MODE_WORD;
		end else begin
			eff_mode = mode;
		end
	end

	always_comb begin
		step.n          = 2'd0;
		step.r0         = end_mark;
		step.r1         = end_mark;
		step.mode       = mode;
		step.held_char  = held_char;
		step.held_valid = held_valid;
		case (eff_mode)
			stl_pkg::MODE_SLASH: begin
				// second slash: comment
				step.mode       = stl_pkg::MODE_COMMENT;
				step.held_char  = stl_pkg::CH_NUL;
				step.held_valid = 1'b0;
			end
			stl_pkg::MODE_COMMENT: begin
				if (is_nul) begin
					step.n    = 2'd1;
					step.mode = stl_pkg::MODE_IDLE;
				end else if (text_byte == stl_pkg::CH_NL) begin
					step.mode = stl_pkg::MODE_IDLE;
				end
			end
			stl_pkg::MODE_WORD: begin
				if (is_ws || is_sgl) begin
					step.r0 = stl_pkg::mk(held_char, 1'b1, stl_pkg::KIND_WORD, 1'b0);
					step.n  = 2'd1;
					if (is_nul) begin
						step.n = 2'd2;
					end else if (is_sgl) begin
						step.n  = 2'd2;
						step.r1 = stl_pkg::mk(text_byte, 1'b1, stl_pkg::KIND_SINGLE, 1'b0);
					end
					step.held_char  = stl_pkg::CH_NUL;
					step.held_valid = 1'b0;
					step.mode       = stl_pkg::MODE_IDLE;
				end else begin
					step.r0         = stl_pkg::mk(held_char, 1'b0, stl_pkg::KIND_WORD, 1'b0);
					step.n          = 2'd1;
					step.held_char  = text_byte;
					step.held_valid = 1'b1;
					step.mode       = stl_pkg::MODE_WORD;
				end
			end
			stl_pkg::MODE_QUOTE: begin
				if (text_byte == stl_pkg::CH_DQUOT || is_nul) begin
					if (held_valid) begin
						step.r0 = stl_pkg::mk(held_char, 1'b1, stl_pkg::KIND_QUOTED, 1'b0);
					end else begin
						step.r0 = stl_pkg::mk(stl_pkg::CH_NUL, 1'b1, stl_pkg::KIND_QUOTED, 1'b1);
					end
					step.n          = is_nul ? 2'd2 : 2'd1;
					step.held_char  = stl_pkg::CH_NUL;
					step.held_valid = 1'b0;
					step.mode       = stl_pkg::MODE_IDLE;
				end else begin
					step.r0         = stl_pkg::mk(held_char, 1'b0, stl_pkg::KIND_QUOTED, 1'b0);
					step.n          = held_valid ? 2'd1 : 2'd0;
					step.held_char  = text_byte;
					step.held_valid = 1'b1;
				end
			end
			default: begin
				// idle and unused codes
				step.mode       = stl_pkg::MODE_IDLE;
				step.held_char  = stl_pkg::CH_NUL;
				step.held_valid = 1'b0;
				if (is_nul) begin
					step.n = 2'd1;
				end else if (is_ws) begin
					step.n = 2'd0;
				end else if (text_byte == stl_pkg::CH_SLASH) begin
					step.mode       = stl_pkg::MODE_SLASH;
					step.held_char  = text_byte;
					step.held_valid = 1'b1;
				end else if (text_byte == stl_pkg::CH_DQUOT) begin
					step.mode = stl_pkg::MODE_QUOTE;
				end else if (is_sgl) begin
					step.n  = 2'd1;
					step.r0 = stl_pkg::mk(text_byte, 1'b1, stl_pkg::KIND_SINGLE, 1'b0);
				end else begin
					step.mode       = stl_pkg::MODE_WORD;
					step.held_char  = text_byte;
					step.held_valid = 1'b1;
				end
			end
		endcase
	end

endmodule

### rtl/core/stl_queue.sv
// stl_queue: small result queue, up to two beats in, one beat out per cycle on pop.
// Depends on stl_pkg.
module stl_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  stl_pkg::result_t push_r0,
	input  stl_pkg::result_t push_r1,
	input  logic             pop,
	output logic             room2,
	output logic             not_empty,
	output stl_pkg::result_t head
);

	stl_pkg::result_t              mem_q [stl_pkg::QDepth];
	logic [stl_pkg::QPtrW-1:0]     wr_ptr_q;
	logic [stl_pkg::QPtrW-1:0]     rd_ptr_q;
	logic [stl_pkg::QCntW-1:0]     count_q;
	logic [stl_pkg::QPtrW-1:0]     wr_ptr1;

	assign wr_ptr1   = wr_ptr_q + stl_pkg::QPtrW'(1);
	assign room2     = (count_q <= stl_pkg::QCntW'(stl_pkg::QDepth - 2));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= push_r0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_ptr1] <= push_r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + stl_pkg::QPtrW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + stl_pkg::QPtrW'(1);
			end
			count_q <= count_q + stl_pkg::QCntW'(push_n) - stl_pkg::QCntW'(pop);
		end
	end

endmodule

### rtl/core/script_token_lexer.sv
// script_token_lexer: top level of the script text tokenizer.
// Depends on stl_pkg, stl_step and stl_queue.
//
// Splits script text, one byte per beat, into a stream of token characters.
// Bytes 1..32 are white space, "//" starts a comment up to newline, a double
// quote starts a quoted token, and { } ( ) ' , are one-character tokens that
// also end a word. Each token character goes out as its own beat with
// token_last set on the final one; one character is held back so that mark
// can be given. An empty quoted token yields a single beat with token_empty.
// Byte 0 closes any open token and yields an end marker (kind 3).
// Rate: one text byte per cycle. Each byte is stepped in the cycle it is
// taken and its zero, one or two result beats go into a four-entry queue;
// the output drains one beat per cycle while out_stall is low. Input stall
// rises whenever the queue has fewer than two free entries. The queue
// registers each byte's beats on their way to the output.
module script_token_lexer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] token_char,
	output logic       token_last,
	output logic [1:0] token_kind,
	output logic       token_empty
);

	// lexer state
	logic [stl_pkg::ModeW-1:0] mode_q;
	logic [7:0]                held_char_q;
	logic                      held_valid_q;

	stl_pkg::step_t   step;
	stl_pkg::result_t head;
	logic             room2;
	logic             not_empty;
	logic             in_take;
	logic             out_take;

	assign in_stall = !room2;
	assign in_take  = in_valid && room2;
	assign out_take = not_empty && !out_stall;

	stl_step u_step (
		.text_byte  (text_byte),
		.mode       (mode_q),
		.held_char  (held_char_q),
		.held_valid (held_valid_q),
		.step       (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= stl_pkg::MODE_IDLE;
			held_char_q  <= stl_pkg::CH_NUL;
			held_valid_q <= 1'b0;
		end else if (in_take) begin
			mode_q       <= step.mode;
			held_char_q  <= step.held_char;
			held_valid_q <= step.held_valid;
		end
	end

	// result beats; the queue keeps the output side decoupled from input
	stl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (in_take ? step.n : 2'd0),
		.push_r0   (step.r0),
		.push_r1   (step.r1),
		.pop       (out_take),
		.room2     (room2),
		.not_empty (not_empty),
		.head      (head)
	);

	assign out_valid   = not_empty;
	assign token_char  = head.ch;
	assign token_last  = head.last;
	assign token_kind  = head.kind;
	assign token_empty = head.empty;

endmodule

### dv/tb.sv
// tb: self-checking testbench for script_token_lexer.
// Depends on stl_pkg and script_token_lexer; predicts every output beat from the text stream.
module tb;

	// Watchdog: cycles with no beat taken on either side before the run is abandoned.
	localparam int WatchdogCycles = 3000;
	// Output hold-off used to back the lexer up into its input.
	localparam int HoldOffCycles  = 300;
	// Settle time after the last expected beat.
	localparam int DrainCycles    = 20;

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] text_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] token_char;
	logic       token_last;
	logic [1:0] token_kind;
	logic       token_empty;

	script_token_lexer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.text_byte  (text_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.token_char (token_char),
		.token_last (token_last),
		.token_kind (token_kind),
		.token_empty(token_empty)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Token predictor: own copy of the lexer state, stepped on every
	// accepted text beat. Expected output beats queue up in order.
	// ------------------------------------------------------------------
	logic [stl_pkg::ModeW-1:0] lx_mode = stl_pkg::MODE_IDLE;
	logic [7:0]                lx_held = 8'h00;
	logic                      lx_held_ok = 1'b0;
	stl_pkg::result_t          pending_tokens[$];

	int beat_errors = 0;
	int idle_cycles = 0;
	int sent_items  = 0;

	function automatic logic is_punct(input logic [7:0] b);
		case (b)
			stl_pkg::CH_LBRC, stl_pkg::CH_RBRC, stl_pkg::CH_LPAR, stl_pkg::CH_RPAR,
			stl_pkg::CH_SQUOT, stl_pkg::CH_COMMA: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic push_beat(input logic [7:0] ch, input logic last, input logic [1:0] kind,
		input logic empty);
		stl_pkg::result_t r;
		r.ch    = ch;
		r.last  = last;
		r.kind  = kind;
		r.empty = empty;
		pending_tokens.push_back(r);
	endtask

	task automatic drop_held();
		lx_held    = 8'h00;
		lx_held_ok = 1'b0;
	endtask

	task automatic lex_byte(input logic [7:0] b);
		logic [stl_pkg::ModeW-1:0] m;
		m = lx_mode;
		// A pending slash either opens a comment or becomes the first word char.
		if (m == stl_pkg::MODE_SLASH) begin
			if (b == stl_pkg::CH_SLASH) begin
				lx_mode = stl_pkg::MODE_COMMENT;
				drop_held();
				return;
			end
			m = stl_pkg::MODE_WORD;
		end
		case (m)
			stl_pkg::MODE_COMMENT: begin
				if (b == stl_pkg::CH_NUL) begin
					push_beat(stl_pkg::CH_NUL, 1'b1, stl_pkg::KIND_END, 1'b0);
					lx_mode = stl_pkg::MODE_IDLE;
				end else if (b == stl_pkg::CH_NL) begin
					lx_mode = stl_pkg::MODE_IDLE;
				end
			end
			stl_pkg::MODE_WORD: begin
				// white space, NUL and punctuation all close the word
				if (b <= stl_pkg::CH_SPACE || is_punct(b)) begin
					push_beat(lx_held, 1'b1, stl_pkg::KIND_WORD, 1'b0);
					drop_held();
					lx_mode = stl_pkg::MODE_IDLE;
					if (b == stl_pkg::CH_NUL)
						push_beat(stl_pkg::CH_NUL, 1'b1, stl_pkg::KIND_END, 1'b0);
					else if (is_punct(b))
						push_beat(b, 1'b1, stl_pkg::KIND_SINGLE, 1'b0);
				end else begin
					push_beat(lx_held, 1'b0, stl_pkg::KIND_WORD, 1'b0);
					lx_held    = b;
					lx_held_ok = 1'b1;
					lx_mode    = stl_pkg::MODE_WORD;
				end
			end
			stl_pkg::MODE_QUOTE: begin
				if (b == stl_pkg::CH_DQUOT || b == stl_pkg::CH_NUL) begin
					if (lx_held_ok)
						push_beat(lx_held, 1'b1, stl_pkg::KIND_QUOTED, 1'b0);
					else
						push_beat(stl_pkg::CH_NUL, 1'b1, stl_pkg::KIND_QUOTED, 1'b1);
					drop_held();
					lx_mode = stl_pkg::MODE_IDLE;
					if (b == stl_pkg::CH_NUL)
						push_beat(stl_pkg::CH_NUL, 1'b1, stl_pkg::KIND_END, 1'b0);
				end else begin
					if (lx_held_ok)
						push_beat(lx_held, 1'b0, stl_pkg::KIND_QUOTED, 1'b0);
					lx_held    = b;
					lx_held_ok = 1'b1;
				end
			end
			default: begin
				// idle; spare mode codes land here too
				lx_mode = stl_pkg::MODE_IDLE;
				drop_held();
				if (b == stl_pkg::CH_NUL) begin
					push_beat(stl_pkg::CH_NUL, 1'b1, stl_pkg::KIND_END, 1'b0);
				end else if (b <= stl_pkg::CH_SPACE) begin
					// white space
				end else if (b == stl_pkg::CH_SLASH) begin
					lx_mode    = stl_pkg::MODE_SLASH;
					lx_held    = b;
					lx_held_ok = 1'b1;
				end else if (b == stl_pkg::CH_DQUOT) begin
					lx_mode = stl_pkg::MODE_QUOTE;
				end else if (is_punct(b)) begin
					push_beat(b, 1'b1, stl_pkg::KIND_SINGLE, 1'b0);
				end else begin
					lx_mode    = stl_pkg::MODE_WORD;
					lx_held    = b;
					lx_held_ok = 1'b1;
				end
			end
		endcase
	endtask

	task automatic report_beat(input string why, input stl_pkg::result_t want,
		input stl_pkg::result_t got);
		beat_errors++;
		if (beat_errors <= 10)
			$display("%0t %s: exp ch=%h last=%b kind=%0d empty=%b, %s",
				$time, why, want.ch, want.last, want.kind, want.empty,
				$sformatf("got ch=%h last=%b kind=%0d empty=%b",
					got.ch, got.last, got.kind, got.empty));
	endtask

	task automatic check_beat();
		stl_pkg::result_t got, want;
		got.ch    = token_char;
		got.last  = token_last;
		got.kind  = token_kind;
		got.empty = token_empty;
		if (pending_tokens.size() == 0) begin
			report_beat("unexpected beat", '0, got);
		end else begin
			want = pending_tokens.pop_front();
			if (got.ch !== want.ch || got.last !== want.last ||
				got.kind !== want.kind || got.empty !== want.empty)
				report_beat("beat mismatch", want, got);
		end
	endtask

	// Both sides are sampled at the edge, before any NBA lands: input beats
	// are predicted first, so a beat can never be checked ahead of its cause.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				lex_byte(text_byte);
			if (out_valid && !out_stall)
				check_beat();
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= WatchdogCycles);
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: stall style is redrawn at the end of each random-length phase. A hold-off
	// request from a test freezes the output for a long stretch.
	// ------------------------------------------------------------------
	rx_style_t rx_style = RX_FREE;
	int        rx_phase_left = 0;
	int        hold_req = 0;
	int        hold_left = 0;

	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (rx_phase_left == 0) begin
			rx_style      = rx_style_t'($urandom_range(0, 3));
			rx_phase_left = $urandom_range(64, 512);
		end else begin
			rx_phase_left--;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (rx_style)
				RX_FREE:  out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:  out_stall <= (rx_phase_left % 3 == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sender: bursts of random length with random gaps; now and then a
	// long gap-free burst. steady_send turns the gaps off entirely.
	// ------------------------------------------------------------------
	int burst_left = 0;
	bit steady_send = 1'b0;

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!steady_send && burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(100, 200);
				gap        = 0;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
					: $urandom_range(0, 3);
			end
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_valid  <= 1'b1;
		text_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_items++;
	endtask

	function automatic logic [7:0] pick_word_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 255));
		while (is_punct(c));
		return c;
	endfunction

	// One well-formed piece of script with random content.
	task automatic send_random_token();
		int sel, len;
		logic [7:0] c;
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			// plain word; usually followed by a space
			do
				c = pick_word_char();
			while (c == stl_pkg::CH_SLASH || c == stl_pkg::CH_DQUOT);
			send_byte(c);
			len = $urandom_range(0, 7);
			repeat (len) send_byte(pick_word_char());
			if ($urandom_range(0, 9) < 7)
				send_byte(stl_pkg::CH_SPACE);
		end else if (sel < 40) begin
			// word opened by a lone slash
			send_byte(stl_pkg::CH_SLASH);
			len = $urandom_range(0, 4);
			repeat (len) send_byte(pick_word_char());
		end else if (sel < 55) begin
			send_byte(stl_pkg::CH_DQUOT);
			len = $urandom_range(0, 6);
			repeat (len) begin
				do
					c = 8'($urandom_range(1, 255));
				while (c == stl_pkg::CH_DQUOT);
				send_byte(c);
			end
			send_byte(stl_pkg::CH_DQUOT);
		end else if (sel < 68) begin
			case ($urandom_range(0, 5))
				0: send_byte(stl_pkg::CH_LBRC);
				1: send_byte(stl_pkg::CH_RBRC);
				2: send_byte(stl_pkg::CH_LPAR);
				3: send_byte(stl_pkg::CH_RPAR);
				4: send_byte(stl_pkg::CH_SQUOT);
				default: send_byte(stl_pkg::CH_COMMA);
			endcase
		end else if (sel < 83) begin
			len = $urandom_range(1, 3);
			repeat (len) send_byte(8'($urandom_range(1, 32)));
		end else if (sel < 93) begin
			send_byte(stl_pkg::CH_SLASH);
			send_byte(stl_pkg::CH_SLASH);
			len = $urandom_range(0, 10);
			repeat (len) begin
				do
					c = 8'($urandom_range(1, 255));
				while (c == stl_pkg::CH_NL);
				send_byte(c);
			end
			send_byte(stl_pkg::CH_NL);
		end else begin
			send_byte(stl_pkg::CH_NUL);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Word of the lowest and highest word bytes cut by a brace, every
	// punctuation token, lowest white space byte.
	task automatic test_words_and_singles();
		send_byte(8'h21);
		send_byte(8'hff);
		send_byte(stl_pkg::CH_LBRC);
		send_byte(stl_pkg::CH_RBRC);
		send_byte(stl_pkg::CH_LPAR);
		send_byte(stl_pkg::CH_RPAR);
		send_byte(stl_pkg::CH_SQUOT);
		send_byte(stl_pkg::CH_COMMA);
		send_byte(8'h01);
	endtask

	// Lone slash starts a word; "//" and a quote inside a word are word chars;
	// space closes it. Then an empty comment ended by newline.
	task automatic test_slashes_and_comments();
		send_byte(stl_pkg::CH_SLASH);
		send_byte("a");
		send_byte(stl_pkg::CH_SLASH);
		send_byte(stl_pkg::CH_SLASH);
		send_byte(stl_pkg::CH_DQUOT);
		send_byte(stl_pkg::CH_SPACE);
		send_byte(stl_pkg::CH_SLASH);
		send_byte(stl_pkg::CH_SLASH);
		send_byte(stl_pkg::CH_NL);
	endtask

	// Empty quoted token, then end of data inside a quoted token.
	task automatic test_quoted_tokens();
		send_byte(stl_pkg::CH_DQUOT);
		send_byte(stl_pkg::CH_DQUOT);
		send_byte(stl_pkg::CH_DQUOT);
		send_byte("q");
		send_byte(stl_pkg::CH_NUL);
	endtask

	// End of data inside a comment, while idle and inside a word.
	task automatic test_end_of_data();
		send_byte(stl_pkg::CH_SLASH);
		send_byte(stl_pkg::CH_SLASH);
		send_byte(stl_pkg::CH_NUL);
		send_byte(stl_pkg::CH_NUL);
		send_byte("w");
		send_byte(stl_pkg::CH_NUL);
	endtask

	task automatic test_token_stream();
		while (sent_items < 1150)
			send_random_token();
	endtask

	// Output frozen while the sender keeps offering: the result queue fills
	// and the lexer must stall its input without losing a beat.
	task automatic test_output_hold_off();
		int stop_at;
		stop_at     = sent_items + 100;
		steady_send = 1'b1;
		hold_req    = HoldOffCycles;
		while (sent_items < stop_at)
			send_random_token();
		steady_send = 1'b0;
	endtask

	// Raw bytes, half of them drawn from the characters the lexer treats specially and 0xff.
	task automatic test_byte_noise();
		logic [7:0] specials[13];
		specials = '{stl_pkg::CH_NUL, stl_pkg::CH_NL, stl_pkg::CH_SPACE, stl_pkg::CH_SLASH,
			stl_pkg::CH_DQUOT, stl_pkg::CH_LBRC, stl_pkg::CH_RBRC, stl_pkg::CH_LPAR,
			stl_pkg::CH_RPAR, stl_pkg::CH_SQUOT, stl_pkg::CH_COMMA, 8'h01, 8'hff};
		repeat (300) begin
			if ($urandom_range(0, 1) == 0)
				send_byte(specials[$urandom_range(0, 12)]);
			else
				send_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_words_and_singles();
		test_slashes_and_comments();
		test_quoted_tokens();
		test_end_of_data();
		test_token_stream();
		test_output_hold_off();
		test_byte_noise();
		in_valid <= 1'b0;

		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (pending_tokens.size() != 0) begin
			$display("%0d expected beats never arrived", pending_tokens.size());
			beat_errors += pending_tokens.size();
		end

		if (beat_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
rtl/core/stl_pkg.sv
rtl/core/stl_step.sv
rtl/core/stl_queue.sv
rtl/core/script_token_lexer.sv
dv/tb.sv
